@@ sv/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and constants for the parallel printer port receiver
// Phase codes, register indexes, reset values and the result beat layout.
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int ACK_LEN_W   = 16;
    localparam int IDLE_CNT_W  = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd1;

    localparam logic [ACK_LEN_W-1:0]  ACK_LENGTH_RST   = 16'd500;
    localparam logic [IDLE_CNT_W-1:0] IDLE_TIMEOUT_RST = 24'd4000;
    localparam logic [IDLE_CNT_W-1:0] IDLE_CNT_MAX     = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_ACK  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       busy_res;
        logic       ack_n;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       job_active;
        logic       job_end;
    } result_t;

endpackage

@@ sv/parallel_printer_port_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// parallel_printer_port_receiver_unit: printer parallel port, peripheral side
// Takes one line sample per beat and returns one beat of driven line state.
// ----------------------------------------------------------------------------
// Each accepted sample (strobe, data, timebase tick) yields exactly one result
// beat, holding busy, ack, the latched byte and job status. One sample is
// accepted every cycle while s_ready is high: the full update is a single pass
// through the core logic into the result register, and a one-entry skid stage
// keeps s_ready registered while m_ready is low. Throughput is one beat per
// cycle while m_ready is high. Config registers (ack_length, idle_timeout) are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while the block is idle (not enforced); unknown indexes are ignored.
module parallel_printer_port_receiver_unit
    import ppr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_strobe_n,
    input  logic [7:0]            s_data_lines,
    input  logic                  s_time_tick,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_busy_res,
    output logic                  m_ack_n,
    output logic                  m_byte_valid,
    output logic [7:0]            m_byte_out,
    output logic                  m_job_active,
    output logic                  m_job_end
);

    logic    in_beat;
    result_t core_result;
    result_t out_result;

    assign in_beat = s_valid && s_ready;

    ppr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .step       (in_beat),
        .strobe_n   (s_strobe_n),
        .data_lines (s_data_lines),
        .time_tick  (s_time_tick),
        .result     (core_result)
    );

    ppr_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_beat),
        .push_data  (core_result),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_result)
    );

    assign m_busy_res   = out_result.busy_res;
    assign m_ack_n      = out_result.ack_n;
    assign m_byte_valid = out_result.byte_valid;
    assign m_byte_out   = out_result.byte_out;
    assign m_job_active = out_result.job_active;
    assign m_job_end    = out_result.job_end;

endmodule

@@ sv/ppr_core.sv @@
// ----------------------------------------------------------------------------
// ppr_core: handshake state and result logic
// Holds the line state, counters and config registers; computes one result
// per accepted sample and advances the state on that beat.
// ----------------------------------------------------------------------------
module ppr_core
    import ppr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  step,
    input  logic                  strobe_n,
    input  logic [7:0]            data_lines,
    input  logic                  time_tick,
    output result_t               result
);

    logic [ACK_LEN_W-1:0]  ack_length_reg;
    logic [IDLE_CNT_W-1:0] idle_timeout_reg;

    logic                  last_strobe_reg, last_strobe_next;
    phase_t                phase_reg, phase_next;
    logic                  pending_reg, pending_next;
    logic                  busy_reg, busy_next;
    logic [ACK_LEN_W-1:0]  ack_cnt_reg, ack_cnt_next;
    logic [IDLE_CNT_W-1:0] idle_cnt_reg, idle_cnt_next;
    logic                  job_reg, job_next;
    logic                  byte_valid;
    logic [7:0]            byte_out;
    logic                  job_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_length_reg   <= ACK_LENGTH_RST;
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_ACK_LENGTH) begin
                ack_length_reg <= cfg_wdata[ACK_LEN_W-1:0];
            end else if (cfg_index == CFG_IDLE_TIMEOUT) begin
                idle_timeout_reg <= cfg_wdata[IDLE_CNT_W-1:0];
            end
        end
    end

    always_comb begin
        last_strobe_next = strobe_n;
        pending_next     = pending_reg;
        busy_next        = busy_reg;
        phase_next       = phase_reg;
        ack_cnt_next     = ack_cnt_reg;
        job_next         = job_reg;
        idle_cnt_next    = idle_cnt_reg;
        byte_valid       = 1'b0;
        byte_out         = 8'd0;
        job_end          = 1'b0;

        // falling strobe edge
        if (last_strobe_reg && !strobe_n) begin
            pending_next = 1'b1;
            busy_next    = 1'b1;
        end

        if (time_tick && idle_cnt_reg != IDLE_CNT_MAX) begin
            idle_cnt_next = idle_cnt_reg + 1'b1;
        end

        case (phase_reg)
            PH_WAIT: begin
                if (strobe_n) begin
                    byte_valid    = 1'b1;
                    byte_out      = data_lines;
                    idle_cnt_next = '0;
                    busy_next     = pending_next;
                    ack_cnt_next  = ack_length_reg;
                    phase_next    = PH_ACK;
                end
            end
            PH_ACK: begin
                // zero length behaves as one
                if (ack_cnt_reg <= ACK_LEN_W'(1)) begin
                    ack_cnt_next = '0;
                    phase_next   = PH_IDLE;
                end else begin
                    ack_cnt_next = ack_cnt_reg - 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (pending_next) begin
                    pending_next  = 1'b0;
                    job_next      = 1'b1;
                    idle_cnt_next = '0;
                    phase_next    = PH_WAIT;
                end
            end
        endcase

        if (phase_next == PH_IDLE && !pending_next && job_next &&
            idle_cnt_next > idle_timeout_reg) begin
            job_next = 1'b0;
            job_end  = 1'b1;
        end

        result.busy_res   = busy_next;
        result.ack_n      = (phase_next != PH_ACK);
        result.byte_valid = byte_valid;
        result.byte_out   = byte_out;
        result.job_active = job_next;
        result.job_end    = job_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_strobe_reg <= 1'b1;
            phase_reg       <= PH_IDLE;
            pending_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            ack_cnt_reg     <= '0;
            idle_cnt_reg    <= '0;
            job_reg         <= 1'b0;
        end else if (step) begin
            last_strobe_reg <= last_strobe_next;
            phase_reg       <= phase_next;
            pending_reg     <= pending_next;
            busy_reg        <= busy_next;
            ack_cnt_reg     <= ack_cnt_next;
            idle_cnt_reg    <= idle_cnt_next;
            job_reg         <= job_next;
        end
    end

endmodule

@@ sv/ppr_obuf.sv @@
// ----------------------------------------------------------------------------
// ppr_obuf: result register with skid stage
// Output register plus one skid entry so the input side's ready comes from a
// register; one more result is taken while the result side stalls.
// ----------------------------------------------------------------------------
module ppr_obuf
    import ppr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up this cycle
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
                if (push) begin
                    out_reg <= push_data;
                end
            end
        end else if (push) begin
            skid_reg       <= push_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: parallel printer port receiver, line-level handshake check
// Feeds strobe/data/tick samples through the input channel under random
// idling on both sides. Each result beat is checked field by field against a
// predictor of the busy/ack/job logic or a typed row of the directed table,
// across several register settings including both extremes of each register.
// ----------------------------------------------------------------------------
module testbench;
    import ppr_pkg::*;

    // indexes past the two real registers; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int N_PHASES     = 6;
    localparam int N_ROWS       = 23;
    localparam int MAX_PRINT    = 40;

    localparam result_t NO_WANT = '0;

    typedef struct {
        logic       strobe_n;
        logic [7:0] data;
        logic       tick;
        bit         typed;
        result_t    want;
    } stim_row_t;

    typedef struct {
        logic [ACK_LEN_W-1:0]  ack;
        logic [IDLE_CNT_W-1:0] tmo;
        int                    items;
        bit                    calm;
        bit                    hold_high;
    } phase_cfg_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_strobe_n   = 1'b1;
    logic [7:0]            s_data_lines = '0;
    logic                  s_time_tick  = 1'b0;
    logic                  m_ready      = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic                  m_busy_res;
    logic                  m_ack_n;
    logic                  m_byte_valid;
    logic [7:0]            m_byte_out;
    logic                  m_job_active;
    logic                  m_job_end;

    // predictor state and register copies
    logic                  seen_strobe  = 1'b1;
    phase_t                rx_phase     = PH_IDLE;
    logic                  edge_waiting = 1'b0;
    logic                  busy_line    = 1'b0;
    logic [ACK_LEN_W-1:0]  ack_left     = '0;
    logic [IDLE_CNT_W-1:0] quiet_ticks  = '0;
    logic                  job_open     = 1'b0;
    logic [ACK_LEN_W-1:0]  ack_len_reg  = ACK_LENGTH_RST;
    logic [IDLE_CNT_W-1:0] timeout_reg  = IDLE_TIMEOUT_RST;

    result_t port_lines_q[$];
    bit      calm          = 1'b0;
    int      errs          = 0;
    int      beats_checked = 0;
    int      samples_sent  = 0;
    int      bytes_seen    = 0;
    int      jobs_closed   = 0;
    int      cycle_cnt     = 0;

    // timeout is 1 and ack length 0 (acts as 1) while this table runs
    stim_row_t dir_rows [N_ROWS] = '{
        '{1'b1, 8'h00, 1'b0, 1'b1, result_t'{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
        '{1'b0, 8'hA5, 1'b0, 1'b1, result_t'{1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0}},
        '{1'b1, 8'hFF, 1'b1, 1'b1, result_t'{1'b0, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0}},
        '{1'b1, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b1, 1'b1, result_t'{1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
        '{1'b0, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{1'b0, 8'h12, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{1'b0, 8'h55, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'hAA, 1'b1, 1'b0, NO_WANT},
        '{1'b0, 8'h33, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'h80, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h01, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'h7F, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'hFE, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{1'b0, 8'hFF, 1'b1, 1'b0, NO_WANT},
        '{1'b0, 8'hFF, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'hC3, 1'b1, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{1'b1, 8'h00, 1'b1, 1'b0, NO_WANT}
    };

    // default-register phase sits right before a short-ack phase that absorbs
    // its tail pulse; the longest ack runs last and is not waited out
    phase_cfg_t phases [N_PHASES] = '{
        '{16'd2,          24'd3,            180, 1'b0, 1'b0},
        '{16'd1,          24'd0,            180, 1'b0, 1'b0},
        '{16'd0,          24'd12,           180, 1'b0, 1'b0},
        '{ACK_LENGTH_RST, IDLE_TIMEOUT_RST, 420, 1'b0, 1'b0},
        '{16'd4,          24'd40,           220, 1'b0, 1'b0},
        '{16'hFFFF,       IDLE_CNT_MAX,     110, 1'b1, 1'b1}
    };

    parallel_printer_port_receiver_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_strobe_n   (s_strobe_n),
        .s_data_lines (s_data_lines),
        .s_time_tick  (s_time_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_busy_res   (m_busy_res),
        .m_ack_n      (m_ack_n),
        .m_byte_valid (m_byte_valid),
        .m_byte_out   (m_byte_out),
        .m_job_active (m_job_active),
        .m_job_end    (m_job_end)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit take_gap();
        return !calm && ($urandom_range(99) < 17);
    endfunction

    // one sample of the port: edge detect, tick count, phase action, timeout
    function automatic result_t port_step(input logic st, input logic [7:0] dl,
                                          input logic tk);
        result_t r;
        r = '0;
        if (seen_strobe && !st) begin
            edge_waiting = 1'b1;
            busy_line    = 1'b1;
        end
        seen_strobe = st;
        if (tk && quiet_ticks != IDLE_CNT_MAX)
            quiet_ticks = quiet_ticks + 1'b1;
        case (rx_phase)
            PH_WAIT: begin
                if (st) begin
                    r.byte_valid = 1'b1;
                    r.byte_out   = dl;
                    quiet_ticks  = '0;
                    busy_line    = edge_waiting;
                    ack_left     = ack_len_reg;
                    rx_phase     = PH_ACK;
                end
            end
            PH_ACK: begin
                if (ack_left <= 16'd1) begin
                    ack_left = '0;
                    rx_phase = PH_IDLE;
                end else begin
                    ack_left = ack_left - 1'b1;
                end
            end
            default: begin
                rx_phase = PH_IDLE;
                if (edge_waiting) begin
                    edge_waiting = 1'b0;
                    job_open     = 1'b1;
                    quiet_ticks  = '0;
                    rx_phase     = PH_WAIT;
                end
            end
        endcase
        if (rx_phase == PH_IDLE && !edge_waiting && job_open && quiet_ticks > timeout_reg) begin
            job_open  = 1'b0;
            r.job_end = 1'b1;
        end
        r.busy_res   = busy_line;
        r.ack_n      = (rx_phase != PH_ACK);
        r.job_active = job_open;
        return r;
    endfunction

    task automatic report_miss(input string what, input int got, input int want);
        errs++;
        if (errs <= MAX_PRINT)
            $display("%0t beat %0d: %s got %0h want %0h", $time, beats_checked, what, got, want);
    endtask

    task automatic check_beat(input result_t got);
        result_t want;
        if (port_lines_q.size() == 0) begin
            report_miss("unexpected beat", 1, 0);
        end else begin
            want = port_lines_q.pop_front();
            if (got.busy_res !== want.busy_res)
                report_miss("busy_res", got.busy_res, want.busy_res);
            if (got.ack_n !== want.ack_n)
                report_miss("ack_n", got.ack_n, want.ack_n);
            if (got.byte_valid !== want.byte_valid)
                report_miss("byte_valid", got.byte_valid, want.byte_valid);
            if (got.byte_out !== want.byte_out)
                report_miss("byte_out", got.byte_out, want.byte_out);
            if (got.job_active !== want.job_active)
                report_miss("job_active", got.job_active, want.job_active);
            if (got.job_end !== want.job_end)
                report_miss("job_end", got.job_end, want.job_end);
        end
        beats_checked++;
        if (got.byte_valid === 1'b1)
            bytes_seen++;
        if (got.job_end === 1'b1)
            jobs_closed++;
    endtask

    // result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_beat(result_t'{m_busy_res, m_ack_n, m_byte_valid, m_byte_out,
                                 m_job_active, m_job_end});
        m_ready <= !take_gap();
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, port_lines_q.size());
            $display("parallel_printer_port_receiver_unit: mismatch");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_ACK_LENGTH:   ack_len_reg = val[ACK_LEN_W-1:0];
            CFG_IDLE_TIMEOUT: timeout_reg = val[IDLE_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic put_sample(input logic st, input logic [7:0] dl, input logic tk,
                              input bit typed, input result_t want);
        result_t pred;
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_strobe_n   <= st;
        s_data_lines <= dl;
        s_time_tick  <= tk;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pred = port_step(st, dl, tk);
        port_lines_q.push_back(typed ? want : pred);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (port_lines_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly clean strobe cycles, plus quiet stretches for timeouts and noise
    task automatic run_random(input int items, input logic [IDLE_CNT_W-1:0] tmo);
        int         sent;
        int         kind;
        int         span;
        logic [7:0] dl;
        sent = 0;
        while (sent < items) begin
            kind = $urandom_range(9);
            dl   = 8'($urandom);
            if (kind <= 6) begin
                span = $urandom_range(2);
                repeat (span) begin
                    put_sample(1'b1, 8'($urandom), 1'($urandom_range(1)), 1'b0, NO_WANT);
                    sent++;
                end
                span = $urandom_range(3, 1);
                repeat (span) begin
                    put_sample(1'b0, dl, 1'($urandom_range(1)), 1'b0, NO_WANT);
                    sent++;
                end
                put_sample(1'b1, dl, 1'($urandom_range(1)), 1'b0, NO_WANT);
                sent++;
            end else if (kind == 7) begin
                span = (tmo < 18) ? $urandom_range(2 * int'(tmo) + 4, 1)
                                  : $urandom_range(40, 1);
                repeat (span) begin
                    put_sample(1'b1, 8'($urandom), $urandom_range(3) != 0, 1'b0, NO_WANT);
                    sent++;
                end
            end else begin
                span = $urandom_range(4, 1);
                repeat (span) begin
                    put_sample(1'($urandom_range(1)), 8'($urandom),
                               1'($urandom_range(1)), 1'b0, NO_WANT);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        phase_cfg_t pc;
        logic [7:0] dl;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ack length 0 behaves as 1; junk above bit 15 must be dropped
        cfg_write(CFG_ACK_LENGTH, {8'hFF, 16'd0});
        cfg_write(CFG_IDLE_TIMEOUT, 24'd1);
        cfg_write(CFG_SPARE_A, 24'($urandom));
        cfg_write(CFG_SPARE_B, 24'hFF_FFFF);
        cfg_we <= 1'b0;

        foreach (dir_rows[k])
            put_sample(dir_rows[k].strobe_n, dir_rows[k].data, dir_rows[k].tick,
                       dir_rows[k].typed, dir_rows[k].want);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            pc   = phases[p];
            calm = pc.calm;
            cfg_write(CFG_ACK_LENGTH, {8'($urandom), pc.ack});
            cfg_write(CFG_IDLE_TIMEOUT, pc.tmo);
            cfg_we <= 1'b0;
            if (pc.hold_high) begin
                // one byte, then strobe held released inside the long pulse
                dl = 8'($urandom);
                put_sample(1'b1, dl, 1'b1, 1'b0, NO_WANT);
                put_sample(1'b0, dl, 1'b0, 1'b0, NO_WANT);
                put_sample(1'b0, dl, 1'b1, 1'b0, NO_WANT);
                put_sample(1'b1, dl, 1'b0, 1'b0, NO_WANT);
                repeat (pc.items)
                    put_sample(1'b1, 8'($urandom), 1'($urandom_range(1)), 1'b0, NO_WANT);
            end else begin
                run_random(pc.items, pc.tmo);
            end
            wait_drained();
        end
        calm = 1'b0;

        $display("%0d samples over %0d register settings, %0d bytes latched, %0d jobs timed out",
                 samples_sent, N_PHASES + 1, bytes_seen, jobs_closed);
        $display("%0d result beats compared, %0d field errors", beats_checked, errs);
        if (errs == 0)
            $display("parallel_printer_port_receiver_unit: match");
        else
            $display("parallel_printer_port_receiver_unit: mismatch");
        $finish;
    end

endmodule
